// ===== src/lsfs_pkg.sv =====
// ---------------------------------------------------------------------------
// lsfs_pkg: shared definitions for the LED strip frame serializer
// Holds item codes, register indexes, stream constants, the stage
// structs and the stream length function used by the block's modules.
// ---------------------------------------------------------------------------
`default_nettype none

package lsfs_pkg;

    // Store depth and derived widths.
    localparam int MAX_LEDS = 256;
    localparam int ADDR_W   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    // Fixed field widths.
    localparam int COUNT_W  = 9;
    localparam int POS_W    = 11;
    localparam int PIX_W    = 29;
    localparam int CFG_IDX_W = 2;

    // Item kinds.
    localparam logic [1:0] KIND_SET   = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_TICK  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_QUIRK = 2'd1;

    // Byte lanes of one LED frame.
    localparam logic [1:0] LANE_HEAD  = 2'd0;
    localparam logic [1:0] LANE_BLUE  = 2'd1;
    localparam logic [1:0] LANE_GREEN = 2'd2;
    localparam logic [1:0] LANE_RED   = 2'd3;

    // Stream byte constants.
    localparam logic [7:0] HEAD_MARK  = 8'hE0;
    localparam logic [7:0] ZERO_BYTE  = 8'h00;
    localparam logic [7:0] STOP_BYTE  = 8'hFF;

    // Number of start bytes ahead of the LED frames.
    localparam logic [POS_W-1:0] START_BYTES = 11'd4;

    // Store access request from the sequencer.
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [PIX_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } store_req_t;

    // Tick item waiting for its store read to complete.
    typedef struct packed {
        logic       valid;
        logic       is_pixel;
        logic [1:0] lane;
        logic [7:0] fixed_byte;
        logic       last;
    } tick_info_t;

    // Whole stream length: start bytes, LED frames and stop bytes,
    // where the stop section is 4*(1+count/32) bytes long.
    function automatic logic [POS_W-1:0] stream_len(input logic [COUNT_W-1:0] count);
        logic [POS_W-1:0] frames;
        logic [POS_W-1:0] stops;
        frames = {count, 2'b00};
        stops  = {5'd0, count[COUNT_W-1:5], 2'b00} + 11'd4;
        return START_BYTES + frames + stops;
    endfunction

endpackage

`default_nettype wire

// ===== src/led_strip_frame_serializer.sv =====
// ---------------------------------------------------------------------------
// led_strip_frame_serializer: LED strip frame serializer
// Keeps a store of LED pixels and streams start bytes, per-LED frames
// and stop bytes, one byte for each tick item.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  in        in         in_valid / in_ready    kind, pixel_index, red, green,
//                                              blue, brightness
//  out       out        out_valid / out_ready  out_byte, last_byte
//  cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One item is accepted per cycle while no held tick stalls the input. A tick
//  item's pixel store read and byte description are registered on acceptance,
//  and the selected byte is loaded into the output register once that is free.
//  Reset clears the valid bit of every store entry at once, so no clearing
//  pass is needed and items are taken right after reset.
//  When the output register is full and not taken, a pending tick holds
//  and input items stall; set and start items pass while nothing is pending.
//
`default_nettype none

module led_strip_frame_serializer (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [1:0]                    kind,
    input  wire  [7:0]                    pixel_index,
    input  wire  [7:0]                    red,
    input  wire  [7:0]                    green,
    input  wire  [7:0]                    blue,
    input  wire  [4:0]                    brightness,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic [7:0]                    out_byte,
    output logic                          last_byte,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [lsfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [8:0]                    cfg_data
);
    import lsfs_pkg::*;

    store_req_t         store_req;
    tick_info_t         tick_info;
    logic [PIX_W-1:0]   pix_data;
    logic               stage_advance;

    lsfs_sequencer u_sequencer (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .kind          (kind),
        .pixel_index   (pixel_index),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .brightness    (brightness),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stage_advance (stage_advance),
        .store_req     (store_req),
        .tick_info     (tick_info)
    );

    lsfs_pixel_store u_pixel_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_data (pix_data)
    );

    lsfs_byte_out u_byte_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_info     (tick_info),
        .pix_data      (pix_data),
        .stage_advance (stage_advance),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_byte     (last_byte)
    );

endmodule

`default_nettype wire

// ===== src/lsfs_pixel_store.sv =====
// ---------------------------------------------------------------------------
// lsfs_pixel_store: pixel memory with per-entry valid bits
// One write port and one registered read port. Entries never written
// since reset read as zero through their cleared valid bit.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfs_pixel_store (
    input  wire                     clk,
    input  wire                     rst_n,
    input  lsfs_pkg::store_req_t    req,
    output logic [lsfs_pkg::PIX_W-1:0] rd_data
);
    import lsfs_pkg::*;

    logic [PIX_W-1:0]    pix_mem_reg [MAX_LEDS];
    logic [MAX_LEDS-1:0] vld_reg;
    logic [PIX_W-1:0]    rd_data_reg;
    logic                rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            pix_mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= pix_mem_reg[req.rd_addr];
            rd_vld_reg  <= vld_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== src/lsfs_sequencer.sv =====
// ---------------------------------------------------------------------------
// lsfs_sequencer: item decode and stream position tracking
// Holds the configuration registers and the transmission state, turns
// set items into store writes and tick items into store reads plus the
// byte description that the output stage completes.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfs_sequencer (
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire  [1:0]                    kind,
    input  wire  [7:0]                    pixel_index,
    input  wire  [7:0]                    red,
    input  wire  [7:0]                    green,
    input  wire  [7:0]                    blue,
    input  wire  [4:0]                    brightness,
    input  wire                           cfg_valid,
    output logic                          cfg_ready,
    input  wire  [lsfs_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire  [8:0]                    cfg_data,
    input  wire                           stage_advance,
    output lsfs_pkg::store_req_t          store_req,
    output lsfs_pkg::tick_info_t          tick_info
);
    import lsfs_pkg::*;

    logic [COUNT_W-1:0] led_count_reg;
    logic               stop_quirk_reg;
    logic               sending_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [COUNT_W-1:0] tx_count_reg;
    logic [POS_W-1:0]   tx_len_reg;
    logic               tx_quirk_reg;
    tick_info_t         info_reg;
    tick_info_t         info_next;

    logic [COUNT_W-1:0] eff_count;
    logic               accept;
    logic               do_set;
    logic               do_start;
    logic               do_tick;
    logic [POS_W-1:0]   pos_q;
    logic               in_head;
    logic               in_pixels;
    logic               at_last;

    assign cfg_ready = 1'b1;
    assign in_ready  = !info_reg.valid || stage_advance;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        if (32'(led_count_reg) > MAX_LEDS)
        begin
            eff_count = COUNT_W'(MAX_LEDS);
        end
        else
        begin
            eff_count = led_count_reg;
        end
    end

    assign do_set   = accept && (kind == KIND_SET) && ({1'b0, pixel_index} < eff_count);
    assign do_start = accept && (kind == KIND_START) && !sending_reg;
    assign do_tick  = accept && (kind == KIND_TICK) && sending_reg;

    // Position inside the LED frame section, valid once past the start bytes.
    assign pos_q     = pos_reg - START_BYTES;
    assign in_head   = pos_reg < START_BYTES;
    assign in_pixels = !in_head && (pos_q < {tx_count_reg, 2'b00});
    assign at_last   = (pos_reg + 11'd1) >= tx_len_reg;

    always_comb
    begin
        store_req.wr_en   = do_set;
        store_req.wr_addr = ADDR_W'(pixel_index);
        store_req.wr_data = {brightness, blue, green, red};
        store_req.rd_en   = do_tick && in_pixels;
        store_req.rd_addr = ADDR_W'(pos_q[POS_W-1:2]);
    end

    always_comb
    begin
        info_next.valid    = do_tick;
        info_next.is_pixel = in_pixels;
        info_next.lane     = pos_q[1:0];
        info_next.last     = at_last;
        if (in_head || tx_quirk_reg)
        begin
            info_next.fixed_byte = ZERO_BYTE;
        end
        else
        begin
            info_next.fixed_byte = STOP_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            led_count_reg  <= '0;
            stop_quirk_reg <= 1'b0;
            sending_reg    <= 1'b0;
            pos_reg        <= '0;
            tx_count_reg   <= '0;
            tx_len_reg     <= '0;
            tx_quirk_reg   <= 1'b0;
            info_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LED_COUNT:  led_count_reg  <= cfg_data;
                    CFG_STOP_QUIRK: stop_quirk_reg <= cfg_data[0];
                    default:        ;
                endcase
            end

            if (do_start)
            begin
                sending_reg  <= 1'b1;
                pos_reg      <= '0;
                tx_count_reg <= eff_count;
                tx_len_reg   <= stream_len(eff_count);
                tx_quirk_reg <= stop_quirk_reg;
            end
            else if (do_tick)
            begin
                if (at_last)
                begin
                    sending_reg <= 1'b0;
                    pos_reg     <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + 11'd1;
                end
            end

            if (accept)
            begin
                info_reg.valid <= info_next.valid;
            end
            else if (stage_advance)
            begin
                info_reg.valid <= 1'b0;
            end

            if (do_tick)
            begin
                info_reg.is_pixel   <= info_next.is_pixel;
                info_reg.lane       <= info_next.lane;
                info_reg.fixed_byte <= info_next.fixed_byte;
                info_reg.last       <= info_next.last;
            end
        end
    end

    assign tick_info = info_reg;

endmodule

`default_nettype wire

// ===== src/lsfs_byte_out.sv =====
// ---------------------------------------------------------------------------
// lsfs_byte_out: byte selection and output register
// Picks the stream byte from the stored pixel or the fixed byte and
// holds it in the output register until the item is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module lsfs_byte_out (
    input  wire                          clk,
    input  wire                          rst_n,
    input  lsfs_pkg::tick_info_t         tick_info,
    input  wire  [lsfs_pkg::PIX_W-1:0]   pix_data,
    output logic                         stage_advance,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic [7:0]                   out_byte,
    output logic                         last_byte
);
    import lsfs_pkg::*;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       last_byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        if (tick_info.is_pixel)
        begin
            case (tick_info.lane)
                LANE_HEAD:  byte_next = HEAD_MARK | {3'b000, pix_data[28:24]};
                LANE_BLUE:  byte_next = pix_data[23:16];
                LANE_GREEN: byte_next = pix_data[15:8];
                LANE_RED:   byte_next = pix_data[7:0];
                default:    byte_next = ZERO_BYTE;
            endcase
        end
        else
        begin
            byte_next = tick_info.fixed_byte;
        end
    end

    assign stage_advance = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_advance)
        begin
            out_valid_reg <= tick_info.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_advance && tick_info.valid)
        begin
            out_byte_reg  <= byte_next;
            last_byte_reg <= tick_info.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

endmodule

`default_nettype wire

// ===== tb/led_strip_frame_serializer_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// led_strip_frame_serializer_tb: self-checking bench for the LED serializer
// Drives set, start and tick items through the input channel with bursty
// timing, programs the LED count and stop style between phases, and checks
// every emitted strip byte and its last flag against a cycle-free model of
// the pixel store and the frame sequencer kept inside the bench.
// ---------------------------------------------------------------------------

module led_strip_frame_serializer_tb;

    import lsfs_pkg::*;

    localparam logic [1:0] KIND_UNUSED   = 2'd3;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         RANDOM_ITEMS  = 600;
    localparam int         CLAMP_TICKS   = 48;
    localparam int         REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pixel_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [4:0] brightness;
    } strip_item_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } strip_byte_t;

    typedef struct packed {
        logic [4:0] bright;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } pixel_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    wire                  in_ready;
    logic [1:0]           kind;
    logic [7:0]           pixel_index;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [4:0]           brightness;
    wire                  out_valid;
    logic                 out_ready;
    wire  [7:0]           out_byte;
    wire                  last_byte;
    logic                 cfg_valid;
    wire                  cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [8:0]           cfg_data;

    // Bench copy of the block's state.
    pixel_t      shadow_pixels [MAX_LEDS];
    logic [8:0]  shadow_count;
    logic        shadow_quirk;
    logic        shadow_sending;
    int          shadow_pos;
    int          shadow_tx_count;
    logic        shadow_tx_quirk;

    strip_item_t pending_items [$];
    strip_byte_t expected_bytes [$];
    strip_item_t cur_item;

    int mismatches;
    int bytes_checked;
    int items_accepted;
    int streams_started;
    int reg_writes;
    int random_items;
    int burst_left;
    int gap_left;
    int stall_left;
    int recv_mode;
    int mode_timer;
    int idle_cycles;

    led_strip_frame_serializer DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .kind        (kind),
        .pixel_index (pixel_index),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .brightness  (brightness),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .last_byte   (last_byte),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_count(input logic [8:0] count);
        return (int'(count) > MAX_LEDS) ? MAX_LEDS : int'(count);
    endfunction

    // Total bytes of one transmission for an already clamped LED count.
    function automatic int frame_bytes(input int count);
        return 4 + 4 * count + 4 * (1 + count / 32);
    endfunction

    function automatic int pick_index(input int live_count);
        if (live_count == 0 || $urandom_range(0, 7) == 0)
            return $urandom_range(0, 255);
        return $urandom_range(0, live_count - 1);
    endfunction

    task automatic log_failure(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic predict_item(input strip_item_t it);
        int          frame_pos;
        pixel_t      px;
        strip_byte_t nb;
        case (it.kind)
            KIND_SET:
            begin
                if (int'(it.pixel_index) < clamp_count(shadow_count))
                begin
                    px.bright = it.brightness;
                    px.blue   = it.blue;
                    px.green  = it.green;
                    px.red    = it.red;
                    shadow_pixels[it.pixel_index] = px;
                end
            end
            KIND_START:
            begin
                if (!shadow_sending)
                begin
                    shadow_sending  = 1'b1;
                    shadow_pos      = 0;
                    shadow_tx_count = clamp_count(shadow_count);
                    shadow_tx_quirk = shadow_quirk;
                    streams_started++;
                end
            end
            KIND_TICK:
            begin
                if (shadow_sending)
                begin
                    frame_pos = shadow_pos - 4;
                    if (shadow_pos < 4)
                        nb.value = ZERO_BYTE;
                    else if (frame_pos < 4 * shadow_tx_count)
                    begin
                        px = shadow_pixels[frame_pos[9:2]];
                        case (frame_pos[1:0])
                            LANE_HEAD:  nb.value = HEAD_MARK | {3'b000, px.bright};
                            LANE_BLUE:  nb.value = px.blue;
                            LANE_GREEN: nb.value = px.green;
                            default:    nb.value = px.red;
                        endcase
                    end
                    else
                        nb.value = shadow_tx_quirk ? ZERO_BYTE : STOP_BYTE;
                    nb.last = (shadow_pos + 1 >= frame_bytes(shadow_tx_count));
                    if (nb.last)
                    begin
                        shadow_sending = 1'b0;
                        shadow_pos     = 0;
                    end
                    else
                        shadow_pos++;
                    expected_bytes.push_back(nb);
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_item(cur_item);
                items_accepted++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    cur_item = pending_items.pop_front();
                    kind        <= cur_item.kind;
                    pixel_index <= cur_item.pixel_index;
                    red         <= cur_item.red;
                    green       <= cur_item.green;
                    blue        <= cur_item.blue;
                    brightness  <= cur_item.brightness;
                    in_valid    <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks each byte and sets out_ready by one of three moods that change now and then.
    always @(posedge clk)
    begin
        strip_byte_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_bytes.size() == 0)
                    log_failure($sformatf("unexpected byte: out_byte=%02h last_byte=%0b",
                                          out_byte, last_byte));
                else
                begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (out_byte !== want.value || last_byte !== want.last)
                        log_failure($sformatf("byte %0d: out_byte=%02h (exp %02h) last_byte=%0b (exp %0b)",
                                              bytes_checked, out_byte, want.value,
                                              last_byte, want.last));
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (recv_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        if ($urandom_range(0, 9) == 0)
                        begin
                            stall_left = $urandom_range(1, 15);
                            out_ready <= 1'b0;
                        end
                        else
                            out_ready <= 1'b1;
                    end
                endcase
            end
            if (mode_timer == 0)
            begin
                recv_mode  = $urandom_range(0, 2);
                mode_timer = $urandom_range(50, 300);
            end
            else
                mode_timer--;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d bytes still due",
                     idle_cycles, expected_bytes.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_pixel(input logic [7:0] idx, input logic [7:0] r, input logic [7:0] g,
                               input logic [7:0] b, input logic [4:0] br);
        strip_item_t it;
        it.kind        = KIND_SET;
        it.pixel_index = idx;
        it.red         = r;
        it.green       = g;
        it.blue        = b;
        it.brightness  = br;
        pending_items.push_back(it);
    endtask

    // Queues an item with random payload; only sets make use of it.
    task automatic queue_item(input logic [1:0] k, input int idx);
        strip_item_t it;
        it.kind        = k;
        it.pixel_index = idx[7:0];
        it.red         = 8'($urandom_range(0, 255));
        it.green       = 8'($urandom_range(0, 255));
        it.blue        = 8'($urandom_range(0, 255));
        it.brightness  = 5'($urandom_range(0, 31));
        pending_items.push_back(it);
    endtask

    // Ticks with pixel updates and ignored items mixed in. The noise goes ahead
    // of a tick, so a stray start always lands while a stream is running.
    task automatic queue_stream(input int ticks, input int live_count);
        for (int i = 0; i < ticks; i++)
        begin
            case ($urandom_range(0, 19))
                0: queue_item(KIND_START, $urandom_range(0, 255));
                1: queue_item(KIND_UNUSED, $urandom_range(0, 255));
                2, 3, 4:
                begin
                    queue_item(KIND_SET, pick_index(live_count));
                    random_items++;
                end
                default:
                begin
                end
            endcase
            queue_item(KIND_TICK, $urandom_range(0, 255));
            random_items++;
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [8:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        if (idx == CFG_LED_COUNT)
            shadow_count = data;
        else if (idx == CFG_STOP_QUIRK)
            shadow_quirk = data[0];
    endtask

    // Waits until every queued item is taken and every byte is back, then lets
    // the pipeline settle for items that produce nothing.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_items.size() != 0 || in_valid || expected_bytes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int  gen_left;
        int  live_count;
        int  phase_num;
        int  cut;
        logic [8:0] new_count;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = KIND_SET;
        pixel_index = 8'd0;
        red         = 8'd0;
        green       = 8'd0;
        blue        = 8'd0;
        brightness  = 5'd0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_LED_COUNT;
        cfg_data    = 9'd0;

        for (int i = 0; i < MAX_LEDS; i++)
            shadow_pixels[i] = '0;
        shadow_count    = 9'd0;
        shadow_quirk    = 1'b0;
        shadow_sending  = 1'b0;
        shadow_pos      = 0;
        shadow_tx_count = 0;
        shadow_tx_quirk = 1'b0;
        mismatches      = 0;
        bytes_checked   = 0;
        items_accepted  = 0;
        streams_started = 0;
        reg_writes      = 0;
        random_items    = 0;
        burst_left      = 0;
        gap_left        = 0;
        stall_left      = 0;
        recv_mode       = 0;
        mode_timer      = 0;
        idle_cycles     = 0;
        gen_left        = 0;
        phase_num       = 0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: an empty strip gives four start and four stop bytes.
        // Ticks before the start and a second start mid-stream must do nothing.
        queue_item(KIND_TICK, 0);
        queue_item(KIND_UNUSED, 255);
        queue_item(KIND_START, 0);
        repeat (3) queue_item(KIND_TICK, 0);
        queue_item(KIND_START, 0);
        repeat (5) queue_item(KIND_TICK, 0);
        wait_drained();

        // One LED, zero stop bytes. The set past the count is dropped; the pixel
        // rewritten after the start bytes went out shows its new value.
        write_reg(CFG_LED_COUNT, 9'd1);
        write_reg(CFG_STOP_QUIRK, 9'd1);
        queue_pixel(8'd1, 8'hFF, 8'hFF, 8'hFF, 5'd31);
        queue_pixel(8'd0, 8'hFF, 8'hFF, 8'hFF, 5'd31);
        queue_item(KIND_START, 0);
        repeat (4) queue_item(KIND_TICK, 0);
        queue_pixel(8'd0, 8'h5A, 8'h00, 8'hFF, 5'd0);
        repeat (8) queue_item(KIND_TICK, 0);
        wait_drained();

        // Random phases. Some end mid-stream, so the next phase rewrites the
        // registers under a running stream and then finishes it.
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       new_count = 9'd0;
                1:       new_count = 9'd31 + 9'($urandom_range(0, 2));
                2:       new_count = 9'($urandom_range(60, 70));
                3:       new_count = 9'($urandom_range(100, 255));
                default: new_count = 9'($urandom_range(1, 24));
            endcase
            write_reg(CFG_LED_COUNT, new_count);
            if (phase_num < 2 || $urandom_range(0, 2) != 0)
                write_reg(CFG_STOP_QUIRK, 9'($urandom_range(0, 1)));
            live_count = clamp_count(new_count);
            if (gen_left > 0)
            begin
                queue_stream(gen_left, live_count);
                gen_left = 0;
            end
            repeat ($urandom_range(0, 6))
            begin
                queue_item(KIND_SET, pick_index(live_count));
                random_items++;
            end
            queue_item(KIND_START, $urandom_range(0, 255));
            random_items++;
            gen_left = frame_bytes(live_count);
            if (phase_num == 1 || $urandom_range(0, 4) == 0)
                cut = $urandom_range(1, gen_left - 1);
            else
                cut = gen_left;
            queue_stream(cut, live_count);
            gen_left -= cut;
            if (gen_left == 0 && $urandom_range(0, 2) == 0)
                queue_item(KIND_TICK, $urandom_range(0, 255));
            wait_drained();
            phase_num++;
        end

        // Full-size strip: fill the top of the store at the exact limit, then
        // start with a count beyond the store, which must clamp to the limit;
        // the opening frames of that stream are checked.
        write_reg(CFG_LED_COUNT, 9'(MAX_LEDS));
        if (gen_left > 0)
            queue_stream(gen_left, MAX_LEDS);
        queue_pixel(8'd255, 8'h00, 8'hFF, 8'h00, 5'd31);
        queue_pixel(8'd254, 8'hFF, 8'h00, 8'hFF, 5'd0);
        repeat (20) queue_item(KIND_SET, $urandom_range(128, 255));
        wait_drained();
        write_reg(CFG_LED_COUNT, 9'd511);
        write_reg(CFG_STOP_QUIRK, 9'($urandom_range(0, 1)));
        queue_item(KIND_START, 0);
        queue_stream(CLAMP_TICKS, MAX_LEDS);
        wait_drained();

        $display("Run covered %0d input items, %0d register writes and %0d transmissions,",
                 items_accepted, reg_writes, streams_started);
        $display("with %0d strip bytes checked and %0d mismatches.", bytes_checked, mismatches);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
